// ===== hw/rtl/mvsv_pkg.sv =====
package mvsv_pkg;

    localparam int MAX_NEST = 64;
    localparam int DEPTH_W  = $clog2(MAX_NEST + 2);
    localparam int ADDR_W   = $clog2(MAX_NEST);
    localparam int CFG_W    = 20;
    localparam int TOP_W    = CFG_W + 1;
    localparam int ACC_W    = 32;
    localparam int PAY_W    = ACC_W + 1;
    localparam logic [CFG_W-1:0] CFG_RESET = 20'd1000000;

    typedef enum logic [2:0] {
        CLS_END,
        CLS_FIXMAP,
        CLS_FIXARR,
        CLS_PAYLOAD,
        CLS_FIELD,
        CLS_BAD
    } cls_t;

    typedef enum logic [1:0] {
        FK_STR,
        FK_EXT,
        FK_ARR,
        FK_MAP
    } fkind_t;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_FIELD,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_BAD_TYPE,
        ERR_TOO_DEEP,
        ERR_COUNT,
        ERR_TRUNC
    } err_t;

    typedef enum logic {
        ST_RUN,
        ST_POP
    } bstate_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
        cls_t       cls;
        logic [4:0] num;
        fkind_t     fkind;
    } item_t;

endpackage

// ===== hw/rtl/mvsv_front.sv =====
module mvsv_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              buffer_last,
    output logic              q_valid,
    output mvsv_pkg::item_t   q_item,
    input  logic              q_pop
);
    import mvsv_pkg::*;

    item_t      dec;
    item_t      slot_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    // classify the byte as if it stood in type position
    always_comb
    begin
        dec.data_byte   = data_byte;
        dec.buffer_last = buffer_last;
        dec.cls         = CLS_BAD;
        dec.num         = 5'd0;
        dec.fkind       = FK_STR;
        if (data_byte <= 8'h7f || data_byte >= 8'he0)
        begin
            dec.cls = CLS_END;
        end
        else if (data_byte <= 8'h8f)
        begin
            dec.cls = CLS_FIXMAP;
            dec.num = {1'b0, data_byte[3:0]};
        end
        else if (data_byte <= 8'h9f)
        begin
            dec.cls = CLS_FIXARR;
            dec.num = {1'b0, data_byte[3:0]};
        end
        else if (data_byte <= 8'hbf)
        begin
            dec.cls = CLS_PAYLOAD;
            dec.num = data_byte[4:0];
        end
        else if (data_byte inside {8'hc0, 8'hc2, 8'hc3})
        begin
            dec.cls = CLS_END;
        end
        else if (data_byte inside {8'hc4, 8'hd9, 8'hc5, 8'hda, 8'hc6, 8'hdb})
        begin
            dec.cls = CLS_FIELD;
            dec.num = (data_byte inside {8'hc4, 8'hd9}) ? 5'd1 :
                      (data_byte inside {8'hc5, 8'hda}) ? 5'd2 : 5'd4;
        end
        else if (data_byte inside {[8'hc7:8'hc9]})
        begin
            dec.cls   = CLS_FIELD;
            dec.fkind = FK_EXT;
            dec.num   = (data_byte == 8'hc7) ? 5'd1 : (data_byte == 8'hc8) ? 5'd2 : 5'd4;
        end
        else if (data_byte inside {[8'hdc:8'hdf]})
        begin
            dec.cls   = CLS_FIELD;
            dec.fkind = data_byte[1] ? FK_MAP : FK_ARR;
            dec.num   = data_byte[0] ? 5'd4 : 5'd2;
        end
        else if (data_byte inside {[8'hcc:8'hd8]})
        begin
            dec.cls = CLS_PAYLOAD;
            case (data_byte)
                8'hcc, 8'hd0: dec.num = 5'd1;
                8'hcd, 8'hd1, 8'hd4: dec.num = 5'd2;
                8'hce, 8'hd2: dec.num = 5'd4;
                8'hcf, 8'hd3: dec.num = 5'd8;
                8'hd5: dec.num = 5'd3;
                8'hd6: dec.num = 5'd5;
                8'hd7: dec.num = 5'd9;
                default: dec.num = 5'd17;
            endcase
        end
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= dec;
        end
    end

endmodule

// ===== hw/rtl/mvsv_back.sv =====
module mvsv_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mvsv_pkg::CFG_W-1:0]    max_count,
    input  logic                          q_valid,
    input  mvsv_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic                          is_type_byte,
    output logic [6:0]                    nest_level,
    output logic                          value_done,
    output logic [2:0]                    error_code
);
    import mvsv_pkg::*;

    logic [TOP_W-1:0]   mem [MAX_NEST];
    logic [TOP_W-1:0]   rd_reg;
    logic               re;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic               we;

    bstate_t            st_reg, st_next;
    phase_t             ph_reg, ph_next;
    fkind_t             fk_reg, fk_next;
    logic [2:0]         bl_reg, bl_next;
    logic [ACC_W-1:0]   acc_reg, acc_next, acc_n;
    logic [PAY_W-1:0]   pl_reg, pl_next, pl_n;
    logic [DEPTH_W-1:0] dep_reg, dep_next, dep_dec;
    logic [TOP_W-1:0]   top_reg, top_next, top_cur;
    err_t               err_reg, err_next;
    logic               last_reg, last_next, at_reg, at_next;

    logic               ov_reg, ov_next;
    logic               o_at_reg, o_done_reg;
    logic [6:0]         o_lvl_reg;
    err_t               o_err_reg;
    logic               o_load, o_at, o_done;
    err_t               o_err;
    logic               out_free;

    logic               op_end, op_open, op_map, op_pay, fin, done;
    logic [ACC_W-1:0]   open_n;
    logic [PAY_W-1:0]   pay_n;

    assign out_free = !ov_reg || pop;
    assign acc_n    = {acc_reg[ACC_W-9:0], q_item.data_byte};
    assign pl_n     = (pl_reg != '0) ? pl_reg - 1'b1 : pl_reg;
    assign dep_dec  = dep_reg - 1'b1;

    always_comb
    begin
        st_next   = st_reg;
        ph_next   = ph_reg;
        fk_next   = fk_reg;
        bl_next   = bl_reg;
        acc_next  = acc_reg;
        pl_next   = pl_reg;
        dep_next  = dep_reg;
        top_next  = top_reg;
        err_next  = err_reg;
        last_next = last_reg;
        at_next   = at_reg;
        q_pop     = 1'b0;
        op_end    = 1'b0;
        op_open   = 1'b0;
        op_map    = 1'b0;
        op_pay    = 1'b0;
        open_n    = '0;
        pay_n     = '0;
        fin       = 1'b0;
        done      = 1'b0;
        top_cur   = top_reg;
        we        = 1'b0;
        waddr     = dep_dec[ADDR_W-1:0];
        re        = 1'b0;
        raddr     = ADDR_W'(dep_reg - 2'd2);

        if (st_reg == ST_RUN && q_valid && out_free)
        begin
            q_pop     = 1'b1;
            fin       = 1'b1;
            last_next = q_item.buffer_last;
            at_next   = (err_reg == ERR_OK) && (ph_reg == PH_TYPE);
            if (err_reg == ERR_OK)
            begin
                case (ph_reg)
                    PH_TYPE:
                    begin
                        if (dep_reg > DEPTH_W'(MAX_NEST))
                        begin
                            err_next = ERR_TOO_DEEP;
                        end
                        else
                        begin
                            case (q_item.cls)
                                CLS_END: op_end = 1'b1;
                                CLS_FIXMAP, CLS_FIXARR:
                                begin
                                    op_open = 1'b1;
                                    op_map  = (q_item.cls == CLS_FIXMAP);
                                    open_n  = ACC_W'(q_item.num);
                                end
                                CLS_PAYLOAD:
                                begin
                                    op_pay = 1'b1;
                                    pay_n  = PAY_W'(q_item.num);
                                end
                                CLS_FIELD:
                                begin
                                    ph_next  = PH_FIELD;
                                    fk_next  = q_item.fkind;
                                    bl_next  = q_item.num[2:0];
                                    acc_next = '0;
                                end
                                default: err_next = ERR_BAD_TYPE;
                            endcase
                        end
                    end
                    PH_FIELD:
                    begin
                        acc_next = acc_n;
                        bl_next  = (bl_reg != 3'd0) ? bl_reg - 3'd1 : bl_reg;
                        if (bl_next == 3'd0)
                        begin
                            case (fk_reg)
                                FK_STR:
                                begin
                                    op_pay = 1'b1;
                                    pay_n  = {1'b0, acc_n};
                                end
                                FK_EXT:
                                begin
                                    op_pay = 1'b1;
                                    pay_n  = {1'b0, acc_n} + 1'b1;
                                end
                                default:
                                begin
                                    if (acc_n > {{(ACC_W-CFG_W){1'b0}}, max_count})
                                    begin
                                        err_next = ERR_COUNT;
                                    end
                                    else
                                    begin
                                        op_open = 1'b1;
                                        op_map  = (fk_reg == FK_MAP);
                                        open_n  = acc_n;
                                    end
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        pl_next = pl_n;
                        op_end  = (pl_n == '0);
                    end
                endcase
            end
        end
        else if (st_reg == ST_POP && out_free)
        begin
            op_end  = 1'b1;
            top_cur = rd_reg;
            fin     = 1'b1;
        end

        if (op_open && open_n == '0)
        begin
            op_end = 1'b1;
        end
        else if (op_open)
        begin
            we       = (dep_reg != '0);
            top_next = op_map ? {open_n[CFG_W-1:0], 1'b0} : {1'b0, open_n[CFG_W-1:0]};
            dep_next = dep_reg + 1'b1;
            ph_next  = PH_TYPE;
        end
        if (op_pay && pay_n == '0)
        begin
            op_end = 1'b1;
        end
        else if (op_pay)
        begin
            ph_next = PH_PAYLOAD;
            pl_next = pay_n;
        end

        // close one level per pass; a further level needs a stack read
        if (op_end)
        begin
            ph_next = PH_TYPE;
            st_next = ST_RUN;
            if (dep_reg == '0)
            begin
                done = 1'b1;
            end
            else if (top_cur != TOP_W'(1))
            begin
                top_next = top_cur - 1'b1;
            end
            else
            begin
                dep_next = dep_dec;
                if (dep_dec == '0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    re      = 1'b1;
                    st_next = ST_POP;
                    fin     = 1'b0;
                end
            end
        end

        o_load = fin;
        o_at   = at_next;
        o_done = done && (err_next == ERR_OK);
        o_err  = err_next;
        if (fin && last_next)
        begin
            if (err_next == ERR_OK && (ph_next != PH_TYPE || dep_next != '0))
            begin
                o_err = ERR_TRUNC;
            end
            ph_next  = PH_TYPE;
            fk_next  = FK_STR;
            bl_next  = 3'd0;
            acc_next = '0;
            pl_next  = '0;
            err_next = ERR_OK;
        end
        ov_next = o_load ? 1'b1 : (pop ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_RUN;
            ph_reg   <= PH_TYPE;
            fk_reg   <= FK_STR;
            bl_reg   <= 3'd0;
            acc_reg  <= '0;
            pl_reg   <= '0;
            dep_reg  <= '0;
            err_reg  <= ERR_OK;
            last_reg <= 1'b0;
            at_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            ph_reg   <= ph_next;
            fk_reg   <= fk_next;
            bl_reg   <= bl_next;
            acc_reg  <= acc_next;
            pl_reg   <= pl_next;
            dep_reg  <= (fin && last_next) ? '0 : dep_next;
            err_reg  <= err_next;
            last_reg <= last_next;
            at_reg   <= at_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (o_load)
        begin
            o_at_reg   <= o_at;
            o_lvl_reg  <= 7'(dep_next);
            o_done_reg <= o_done;
            o_err_reg  <= o_err;
        end
    end

    // stack below the top entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= top_reg;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign empty        = !ov_reg;
    assign is_type_byte = o_at_reg;
    assign nest_level   = o_lvl_reg;
    assign value_done   = o_done_reg;
    assign error_code   = o_err_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dep_reg <= DEPTH_W'(MAX_NEST + 1))
        else $error("open depth beyond limit");
    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_POP |-> dep_reg != '0 && err_reg == ERR_OK)
        else $error("unwind with no open level");
    a_no_take_unwind: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_POP |-> !q_pop)
        else $error("word taken during unwind");
`endif

endmodule

// ===== hw/rtl/msgpack_value_skip_validator.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------------
// input     | push / full           | data_byte, buffer_last
// result    | empty / pop           | is_type_byte, nest_level, value_done, error_code
// config    | cfg_valid / cfg_ready | cfg_data (max_container_count)
//
// one byte per cycle while the result register is free; a byte that closes a level
// and leaves an outer level open waits for one count stack read per such level.
// a two-word queue sits between the decoder and the parser; a one-word result
// register holds each result, and the parser stalls while it is full and not popped.
// rst_n clears all control state; the count stack needs no clearing.
module msgpack_value_skip_validator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    data_byte,
    input  logic                          buffer_last,
    output logic                          empty,
    input  logic                          pop,
    output logic                          is_type_byte,
    output logic [6:0]                    nest_level,
    output logic                          value_done,
    output logic [2:0]                    error_code,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mvsv_pkg::CFG_W-1:0]    cfg_data
);
    import mvsv_pkg::*;

    logic             q_valid, q_pop;
    item_t            q_item;
    logic [CFG_W-1:0] max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    mvsv_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .buffer_last (buffer_last),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    mvsv_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_count    (max_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .is_type_byte (is_type_byte),
        .nest_level   (nest_level),
        .value_done   (value_done),
        .error_code   (error_code)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mvsv_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [7:0]          data_byte;
    logic                buffer_last;
    logic                empty;
    logic                pop;
    logic                is_type_byte;
    logic [6:0]          nest_level;
    logic                value_done;
    logic [2:0]          error_code;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    typedef struct {
        logic       typ;
        logic [6:0] lvl;
        logic       done;
        err_t       err;
    } verdict_t;

    msgpack_value_skip_validator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .buffer_last  (buffer_last),
        .empty        (empty),
        .pop          (pop),
        .is_type_byte (is_type_byte),
        .nest_level   (nest_level),
        .value_done   (value_done),
        .error_code   (error_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // parser shadow state
    logic [CFG_W-1:0] count_limit;
    phase_t           ph;
    fkind_t           fk;
    int unsigned      fbytes_left;
    logic [31:0]      len_acc;
    logic [32:0]      pay_left;
    int unsigned      depth;
    logic [20:0]      elem_stack [0:MAX_NEST];
    err_t             sticky;

    verdict_t    expected_q [$];
    int          mismatches;
    logic        failed;
    int          hold_off;
    int          gap_pct;
    int          sent_bytes;
    logic        pop_on;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    initial
    begin
        #200ms;
        $display("msgpack_value_skip_validator regression: fail");
        $finish;
    end

    task automatic clear_parser();
        ph = PH_TYPE;
        fk = FK_STR;
        fbytes_left = 0;
        len_acc = '0;
        pay_left = '0;
        depth = 0;
        sticky = ERR_OK;
        for (int i = 0; i <= MAX_NEST; i++)
            elem_stack[i] = '0;
    endtask

    task automatic close_value(ref logic done);
        ph = PH_TYPE;
        forever
        begin
            if (depth == 0)
            begin
                done = 1'b1;
                return;
            end
            if (depth > MAX_NEST + 1)
                return;
            elem_stack[depth-1] = elem_stack[depth-1] - 21'd1;
            if (elem_stack[depth-1] != 0)
                return;
            depth--;
        end
    endtask

    task automatic open_box(logic [31:0] n, logic is_map, ref logic done);
        if (n == 0)
        begin
            close_value(done);
            return;
        end
        if (depth > MAX_NEST)
            return;
        elem_stack[depth] = is_map ? 21'(n << 1) : 21'(n);
        depth++;
        ph = PH_TYPE;
    endtask

    task automatic begin_field(int unsigned nb, fkind_t k);
        ph = PH_FIELD;
        fk = k;
        fbytes_left = nb;
        len_acc = '0;
    endtask

    task automatic begin_payload(logic [32:0] n, ref logic done);
        if (n == 0)
        begin
            close_value(done);
            return;
        end
        ph = PH_PAYLOAD;
        pay_left = n;
    endtask

    task automatic decode_type(logic [7:0] c, ref logic done);
        if (depth > MAX_NEST)
        begin
            sticky = ERR_TOO_DEEP;
            return;
        end
        if (c <= 8'h7f || c >= 8'he0)
            close_value(done);
        else if (c <= 8'h8f)
            open_box({28'd0, c[3:0]}, 1'b1, done);
        else if (c <= 8'h9f)
            open_box({28'd0, c[3:0]}, 1'b0, done);
        else if (c <= 8'hbf)
            begin_payload({28'd0, c[4:0]}, done);
        else
            case (c)
                8'hc0, 8'hc2, 8'hc3: close_value(done);
                8'hc4, 8'hd9: begin_field(1, FK_STR);
                8'hc5, 8'hda: begin_field(2, FK_STR);
                8'hc6, 8'hdb: begin_field(4, FK_STR);
                8'hc7: begin_field(1, FK_EXT);
                8'hc8: begin_field(2, FK_EXT);
                8'hc9: begin_field(4, FK_EXT);
                8'hcc, 8'hd0: begin_payload(33'd1, done);
                8'hcd, 8'hd1, 8'hd4: begin_payload(33'd2, done);
                8'hce, 8'hd2: begin_payload(33'd4, done);
                8'hcf, 8'hd3: begin_payload(33'd8, done);
                8'hd5: begin_payload(33'd3, done);
                8'hd6: begin_payload(33'd5, done);
                8'hd7: begin_payload(33'd9, done);
                8'hd8: begin_payload(33'd17, done);
                8'hdc: begin_field(2, FK_ARR);
                8'hdd: begin_field(4, FK_ARR);
                8'hde: begin_field(2, FK_MAP);
                8'hdf: begin_field(4, FK_MAP);
                default: sticky = ERR_BAD_TYPE;
            endcase
    endtask

    task automatic predict_byte(logic [7:0] c, logic last);
        verdict_t v;
        logic     done;
        logic     at_type;
        done = 1'b0;
        at_type = 1'b0;
        if (sticky == ERR_OK)
        begin
            if (ph == PH_TYPE)
            begin
                at_type = 1'b1;
                decode_type(c, done);
            end
            else if (ph == PH_FIELD)
            begin
                len_acc = {len_acc[23:0], c};
                if (fbytes_left > 0)
                    fbytes_left--;
                if (fbytes_left == 0)
                begin
                    if (fk == FK_STR)
                        begin_payload({1'b0, len_acc}, done);
                    else if (fk == FK_EXT)
                        begin_payload({1'b0, len_acc} + 33'd1, done);
                    else if (len_acc > {12'd0, count_limit})
                        sticky = ERR_COUNT;
                    else
                        open_box(len_acc, fk == FK_MAP, done);
                end
            end
            else
            begin
                if (pay_left > 0)
                    pay_left--;
                if (pay_left == 0)
                    close_value(done);
            end
            if (sticky != ERR_OK)
                done = 1'b0;
        end
        if (last && sticky == ERR_OK && (ph != PH_TYPE || depth != 0))
            sticky = ERR_TRUNC;
        v.typ = at_type;
        v.lvl = 7'(depth);
        v.done = done;
        v.err = sticky;
        expected_q = {expected_q, v};
        if (last)
            clear_parser();
    endtask

    task automatic send_byte(logic [7:0] c, logic last = 1'b0);
        push <= 1'b1;
        data_byte <= c;
        buffer_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_bytes++;
        predict_byte(c, last);
        if ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_limit = val;
    endtask

    task automatic send_bytes(logic [7:0] b [$]);
        foreach (b[i])
            send_byte(b[i]);
    endtask

    task automatic send_len(logic [31:0] n, int nb);
        for (int i = nb - 1; i >= 0; i--)
            send_byte(n[i*8 +: 8]);
    endtask

    // one random value, not always well-formed (0xc1)
    task automatic send_value(int lvl);
        int k;
        int n;
        k = $urandom_range(0, 11);
        if (lvl > 4 && k >= 9)
            k = 0;
        case (k)
            0: send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                              : 8'($urandom_range(224, 255)));
            1: send_byte(8'(8'hc0 + 2 * $urandom_range(0, 1) + $urandom_range(0, 1)));
            2:
            begin
                n = $urandom_range(0, 6);
                send_byte(8'(8'ha0 + n));
                repeat (n) send_byte(8'($urandom));
            end
            3:
            begin
                k = $urandom_range(0, 7);
                send_byte(8'(8'hcc + (k < 4 ? k : k + 0)));
                repeat (1 << (k % 4)) send_byte(8'($urandom));
            end
            4:
            begin
                k = $urandom_range(0, 4);
                send_byte(8'(8'hd4 + k));
                repeat (k == 0 ? 2 : k == 1 ? 3 : k == 2 ? 5 : k == 3 ? 9 : 17)
                    send_byte(8'($urandom));
            end
            5:
            begin
                k = $urandom_range(0, 5);
                n = $urandom_range(0, 5);
                case (k)
                    0: begin send_byte(8'hc4); send_len(n, 1); end
                    1: begin send_byte(8'hc5); send_len(n, 2); end
                    2: begin send_byte(8'hc6); send_len(n, 4); end
                    3: begin send_byte(8'hd9); send_len(n, 1); end
                    4: begin send_byte(8'hda); send_len(n, 2); end
                    default: begin send_byte(8'hdb); send_len(n, 4); end
                endcase
                repeat (n) send_byte(8'($urandom));
            end
            6:
            begin
                k = $urandom_range(0, 2);
                n = $urandom_range(0, 4);
                send_byte(8'(8'hc7 + k));
                send_len(n, k == 0 ? 1 : k == 1 ? 2 : 4);
                repeat (n + 1) send_byte(8'($urandom));
            end
            7, 8:
            begin
                n = $urandom_range(0, 3);
                send_byte(8'((k == 7 ? 8'h90 : 8'h80) + n));
                repeat (k == 7 ? n : 2 * n) send_value(lvl + 1);
            end
            default:
            begin
                n = $urandom_range(0, 3);
                k = $urandom_range(0, 3);
                send_byte(8'(8'hdc + k));
                send_len(n, k[0] ? 4 : 2);
                repeat (k[1] ? 2 * n : n) send_value(lvl + 1);
            end
        endcase
    endtask

    task automatic test_directed();
        logic [7:0] q [$];
        gap_pct = 20;
        send_byte(8'h00);
        send_byte(8'h7f);
        send_byte(8'he0);
        send_byte(8'hff, 1'b1);
        q = '{8'h92, 8'h01, 8'h81, 8'h02, 8'h03};
        send_bytes(q);
        q = '{8'h80, 8'h90, 8'ha0, 8'hc4};
        send_bytes(q);
        send_byte(8'h00, 1'b1);
        send_byte(8'hc1);
        send_byte(8'h05, 1'b1);
        send_byte(8'hca, 1'b1);
        send_byte(8'hcb);
        send_byte(8'h01, 1'b1);
        send_byte(8'hcf);
        send_byte(8'h01, 1'b1);
        send_byte(8'hdf);
        q = '{8'hff, 8'hff, 8'hff};
        send_bytes(q);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_too_deep();
        repeat (MAX_NEST + 1)
            send_byte(8'h91);
        send_byte(8'h91);
        send_byte(8'h01, 1'b1);
        repeat (MAX_NEST)
            send_byte(8'h91);
        send_byte(8'h01, 1'b1);
        // deep stack unwound by a single byte
        repeat (MAX_NEST)
            send_byte(8'h91);
        send_byte(8'h01);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_limits();
        write_limit('0);
        send_bytes('{8'hdc, 8'h00, 8'h00, 8'hde, 8'h00});
        send_byte(8'h01, 1'b1);
        write_limit(20'd1);
        send_bytes('{8'hdd, 8'h00, 8'h00, 8'h00, 8'h01, 8'h05});
        send_bytes('{8'hde, 8'h00, 8'h01, 8'h01, 8'h02});
        send_bytes('{8'hdc, 8'h00});
        send_byte(8'h02, 1'b1);
        write_limit(20'hfffff);
        send_bytes('{8'hdd, 8'h00, 8'h0f, 8'hff, 8'hff});
        send_byte(8'h00, 1'b1);
        send_bytes('{8'hdd, 8'h00, 8'h10, 8'h00});
        send_byte(8'h00, 1'b1);
        write_limit(20'd2);
    endtask

    // keeps sending until the total byte count reaches target
    task automatic test_random(int target);
        while (sent_bytes < target)
        begin
            gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 50);
            if ($urandom_range(0, 9) < 8)
            begin
                repeat ($urandom_range(1, 4))
                    send_value(0);
                if ($urandom_range(0, 2) == 0)
                    send_value(0);
                send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end
            else
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 29) == 0)
                write_limit(20'($urandom_range(0, 8)));
        end
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_backpressure();
        gap_pct = 0;
        hold_off = 300;
        repeat (12)
            send_value(0);
        send_byte(8'h00, 1'b1);
        drain();
        repeat (8)
            send_value(0);
        send_byte(8'hc0, 1'b1);
    endtask

    // result receiver with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_on <= 1'b1;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                pop_on <= !pop_on;
            pop <= pop_on ? 1'b1 : ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: typ %0d lvl %0d done %0d err %0d",
                             is_type_byte, nest_level, value_done, error_code);
            end
            else
            begin
                v = expected_q.pop_front();
                if (is_type_byte !== v.typ || nest_level !== v.lvl ||
                    value_done !== v.done || error_code !== v.err)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 v.typ, v.lvl, v.done, v.err,
                                 is_type_byte, nest_level, value_done, error_code);
                end
            end
        end
    end

    initial
    begin
        failed = 1'b0;
        mismatches = 0;
        hold_off = 0;
        gap_pct = 0;
        sent_bytes = 0;
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = '0;
        buffer_last = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        count_limit = CFG_RESET;
        clear_parser();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_too_deep();
        test_limits();
        test_backpressure();
        test_random(1900);
        drain();
        if (expected_q.size() != 0)
            failed = 1'b1;
        if (!failed)
            $display("msgpack_value_skip_validator regression: pass");
        else
            $display("msgpack_value_skip_validator regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mvsv_pkg.sv
hw/rtl/mvsv_front.sv
hw/rtl/mvsv_back.sv
hw/rtl/msgpack_value_skip_validator.sv
bench/testbench.sv
